// ===== design/sgs_pkg.sv =====
// ----------------------------------------------------------------------------
// sgs_pkg - shared types and constants of the silence gap segmenter
// Field widths, register indexes, reset values and small helpers.
// ----------------------------------------------------------------------------
package sgs_pkg;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = 32;
    localparam int SEG_W      = 16;
    localparam int BOUND_W    = 16;
    localparam int CU_W       = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // sample lanes carried by one input beat
    localparam int LANES_IN     = 2;
    localparam int CHANNELS_DEF = 2;

    // beat layouts
    localparam int S_TDATA_W   = LANES_IN * SAMPLE_W;
    localparam int M_PAYLOAD_W = 2 + 2 * CNT_W + SEG_W;
    localparam int M_TDATA_W   = ((M_PAYLOAD_W + 7) / 8) * 8;

    // register reset values
    localparam logic [BOUND_W-1:0] BOUND_RST    = 16'd983;
    localparam logic [CNT_W-1:0]   GAP_RST      = 32'd88200;
    localparam logic [CNT_W-1:0]   OVR_RST      = 32'd0;
    localparam logic [CNT_W-1:0]   MIN_SEG_RST  = 32'd0;
    localparam logic [CU_W-1:0]    CU_RST       = 2'd2;
    localparam logic [SEG_W-1:0]   FIRST_SEG_RST = 16'd0;

    // register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SILENCE_BOUNDARY     = 3'd0,
        REG_GAP_SAMPLES          = 3'd1,
        REG_OVERRIDE_SAMPLES     = 3'd2,
        REG_OVERRIDE_ENABLE      = 3'd3,
        REG_MIN_SEGMENT_FRAMES   = 3'd4,
        REG_DROP_QUIET           = 3'd5,
        REG_CHANNELS_USED        = 3'd6,
        REG_FIRST_SEGMENT_NUMBER = 3'd7
    } cfg_addr_t;

    // settings seen by the merge stage
    typedef struct packed {
        logic [CNT_W-1:0] gap_samples;
        logic [CNT_W-1:0] override_samples;
        logic             override_enable;
        logic [CNT_W-1:0] min_segment_frames;
        logic             drop_quiet;
        logic [CU_W-1:0]  channels_used;
    } cfg_t;

    // segment number preset from a register write
    typedef struct packed {
        logic             load;
        logic [SEG_W-1:0] value;
    } seg_preset_t;

    // one result beat
    typedef struct packed {
        logic [SEG_W-1:0] segment_number;
        logic [CNT_W-1:0] ended_kept_frames;
        logic [CNT_W-1:0] ended_frames;
        logic             split_here;
        logic             keep_frame;
    } result_t;

    // saturating increment of a frame or sample counter
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        return (x == '1) ? x : x + CNT_W'(1);
    endfunction

endpackage

// ===== design/silence_gap_segmenter_unit.sv =====
// ----------------------------------------------------------------------------
// silence_gap_segmenter_unit - audio silence gap segmenter
// Splits a stream of audio frames into segments at long silent runs.
// ----------------------------------------------------------------------------
// One frame beat per clock is taken while the result output is not stalled, and
// one result beat per frame is given: the lane detectors register a silence flag
// per sample, then the merge stage updates the silent run, makes the split
// decision and loads the result register. The throughput of one frame per cycle
// is set by the run and segment counter update in the merge stage. Registers are
// written through a plain write port and must only change while no frame is in
// flight; writing the first segment number also presets the current segment
// number.
// ----------------------------------------------------------------------------
module silence_gap_segmenter_unit import sgs_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // register write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // frame input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // sample_first, sample_second
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata   // keep_frame, split_here, ended_frames,
                                            // ended_kept_frames, segment_number, pad
);

    localparam int LANES = (CHANNELS < LANES_IN) ? CHANNELS : LANES_IN;

    logic [BOUND_W-1:0] boundary_reg;
    cfg_t               cfg_reg;
    seg_preset_t        preset;
    cfg_addr_t          addr;

    logic               s1_valid_reg, s1_valid_next;
    logic               out_free;
    logic               in_beat;
    logic [LANES-1:0]   quiet;
    result_t            result;

    // register writes
    assign addr = cfg_addr_t'(cfg_addr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boundary_reg               <= BOUND_RST;
            cfg_reg.gap_samples        <= GAP_RST;
            cfg_reg.override_samples   <= OVR_RST;
            cfg_reg.override_enable    <= 1'b0;
            cfg_reg.min_segment_frames <= MIN_SEG_RST;
            cfg_reg.drop_quiet         <= 1'b0;
            cfg_reg.channels_used      <= CU_RST;
        end else if (cfg_we) begin
            unique case (addr)
                REG_SILENCE_BOUNDARY:     boundary_reg <= cfg_wdata[BOUND_W-1:0];
                REG_GAP_SAMPLES:          cfg_reg.gap_samples <= cfg_wdata[CNT_W-1:0];
                REG_OVERRIDE_SAMPLES:     cfg_reg.override_samples <= cfg_wdata[CNT_W-1:0];
                REG_OVERRIDE_ENABLE:      cfg_reg.override_enable <= cfg_wdata[0];
                REG_MIN_SEGMENT_FRAMES:   cfg_reg.min_segment_frames <= cfg_wdata[CNT_W-1:0];
                REG_DROP_QUIET:           cfg_reg.drop_quiet <= cfg_wdata[0];
                REG_CHANNELS_USED:        cfg_reg.channels_used <= cfg_wdata[CU_W-1:0];
                REG_FIRST_SEGMENT_NUMBER: ;
                default: ;
            endcase
        end
    end

    // segment number preset goes straight to the merge stage
    assign preset.load  = cfg_we && (addr == REG_FIRST_SEGMENT_NUMBER);
    assign preset.value = cfg_wdata[SEG_W-1:0];

    // handshake and lane stage valid
    assign out_free = !m_tvalid || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign in_beat  = s_tvalid && s_tready;

    always_comb begin
        if (in_beat) begin
            s1_valid_next = 1'b1;
        end else if (out_free) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // lane detectors
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        sgs_lane u_lane (
            .aclk     (aclk),
            .load     (s_tready),
            .sample   (s_tdata[g*SAMPLE_W +: SAMPLE_W]),
            .boundary (boundary_reg),
            .quiet    (quiet[g])
        );
    end

    // merge stage
    sgs_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .preset    (preset),
        .in_valid  (s1_valid_reg),
        .quiet     (quiet),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .result    (result)
    );

    // result beat packing
    assign m_tdata = {(M_TDATA_W - M_PAYLOAD_W)'(0), result};

    // an empty output side never stalls the input
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // an accepted beat always reaches the lane stage
    a_beat_in_lane_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> s1_valid_reg)
        else $error("accepted beat lost before lane stage");

    // with silence skipping, the frame that opens a segment is dropped
    a_split_dropped_on_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result.split_here && cfg_reg.drop_quiet) |-> !result.keep_frame)
        else $error("split frame kept while skipping silence");

endmodule

// ===== design/sgs_lane.sv =====
// ----------------------------------------------------------------------------
// sgs_lane - per-lane silence detector
// Flags a sample whose magnitude is strictly below the boundary.
// ----------------------------------------------------------------------------
module sgs_lane import sgs_pkg::*; (
    input  logic                       aclk,
    input  logic                       load,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [BOUND_W-1:0]         boundary,
    output logic                       quiet
);

    logic [SAMPLE_W:0] mag;
    logic              quiet_next;
    logic              quiet_reg;

    // magnitude in one extra bit so that the most negative code fits
    always_comb begin
        if (sample[SAMPLE_W-1]) begin
            mag = (SAMPLE_W+1)'(0) - {sample[SAMPLE_W-1], sample};
        end else begin
            mag = {1'b0, sample};
        end
        quiet_next = mag < {1'b0, boundary};
    end

    // flag register, loads whenever the input side is ready, accepted beat or not
    always_ff @(posedge aclk) begin
        if (load) begin
            quiet_reg <= quiet_next;
        end
    end

    assign quiet = quiet_reg;

endmodule

// ===== design/sgs_merge.sv =====
// ----------------------------------------------------------------------------
// sgs_merge - run length merge and segment decision
// Combines the lane flags into the silent run, decides the split and keeps
// the segment counters; holds the result register.
// ----------------------------------------------------------------------------
module sgs_merge import sgs_pkg::*; #(
    parameter  int CHANNELS   = CHANNELS_DEF,
    localparam int LANES      = (CHANNELS < LANES_IN) ? CHANNELS : LANES_IN,
    localparam int LANE_CNT_W = $clog2(LANES + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  seg_preset_t       preset,
    input  logic              in_valid,
    input  logic [LANES-1:0]  quiet,
    input  logic              out_ready,
    output logic              out_valid,
    output result_t           result
);

    logic [CNT_W-1:0]      run_reg, run_next;
    logic                  marked_reg, marked_next;
    logic [CNT_W-1:0]      frames_reg, frames_next;
    logic [CNT_W-1:0]      kept_reg, kept_next;
    logic [SEG_W-1:0]      seg_reg, seg_next;
    logic                  valid_reg, valid_next;
    result_t               result_reg, result_next;

    logic [CU_W-1:0]       lanes_req;
    logic [LANE_CNT_W-1:0] lanes_used;
    logic [LANE_CNT_W-1:0] trail;
    logic                  all_quiet;
    logic [CNT_W:0]        run_sum;
    logic                  marked_mid;
    logic                  min_ok;
    logic                  over_ok;
    logic                  split;
    logic                  keep;
    logic                  take;

    assign take = in_valid && (!valid_reg || out_ready);

    // lane count limited to the lanes present
    always_comb begin
        lanes_req = (cfg.channels_used == '0) ? CU_W'(1) : cfg.channels_used;
        if (lanes_req > CU_W'(LANES)) begin
            lanes_used = LANE_CNT_W'(LANES);
        end else begin
            lanes_used = LANE_CNT_W'(lanes_req);
        end
    end

    // trailing quiet count across the used lanes
    always_comb begin
        trail     = '0;
        all_quiet = 1'b1;
        for (int i = 0; i < LANES; i++) begin
            if (LANE_CNT_W'(i) < lanes_used) begin
                if (quiet[i]) begin
                    trail = trail + LANE_CNT_W'(1);
                end else begin
                    trail     = '0;
                    all_quiet = 1'b0;
                end
            end
        end
    end

    // run update, split decision and counter updates
    always_comb begin
        run_sum = {1'b0, run_reg} + (CNT_W+1)'(lanes_used);
        if (all_quiet) begin
            run_next = run_sum[CNT_W] ? '1 : run_sum[CNT_W-1:0];
        end else begin
            run_next = CNT_W'(trail);
        end

        marked_mid = (run_next == '0) ? 1'b0 : marked_reg;
        min_ok  = (cfg.min_segment_frames == '0) || (cfg.min_segment_frames <= frames_reg);
        over_ok = cfg.override_enable && (run_next > cfg.override_samples);
        split   = (run_next > cfg.gap_samples) && !marked_mid && (min_ok || over_ok);

        marked_next = split || marked_mid;
        keep        = !(cfg.drop_quiet && marked_next);

        if (split) begin
            seg_next    = seg_reg + SEG_W'(1);
            frames_next = CNT_W'(1);
            kept_next   = keep ? CNT_W'(1) : '0;
        end else begin
            seg_next    = seg_reg;
            frames_next = sat_inc(frames_reg);
            kept_next   = keep ? sat_inc(kept_reg) : kept_reg;
        end

        result_next.keep_frame        = keep;
        result_next.split_here        = split;
        result_next.ended_frames      = split ? frames_reg : '0;
        result_next.ended_kept_frames = split ? kept_reg : '0;
        result_next.segment_number    = seg_next;
    end

    // result valid
    always_comb begin
        if (take) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // segment state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg    <= '0;
            marked_reg <= 1'b0;
            frames_reg <= '0;
            kept_reg   <= '0;
            seg_reg    <= FIRST_SEG_RST;
            valid_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (take) begin
                run_reg    <= run_next;
                marked_reg <= marked_next;
                frames_reg <= frames_next;
                kept_reg   <= kept_next;
            end
            if (preset.load) begin
                seg_reg <= preset.value;
            end else if (take) begin
                seg_reg <= seg_next;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule
